// ===== rtl/core/diff_drive_velocity_to_wheel_rpm_top_defines.svh =====
// Assertion macros for the diff drive velocity to wheel rpm block
`ifndef DIFF_DRIVE_VELOCITY_TO_WHEEL_RPM_TOP_DEFINES_SVH
`define DIFF_DRIVE_VELOCITY_TO_WHEEL_RPM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DVWR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DVWR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DVWR_ASSERT(lbl, clk, rstn, prop, msg)
`define DVWR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/dvwr_pkg.sv =====
// Shared constants and types for the velocity to wheel rpm converter
package dvwr_pkg;

    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 30;
    localparam int DIV_Q_W   = 32;
    localparam int DIV_LAT   = DIV_Q_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int PI_NUM     = 355;
    localparam int PI_DEN     = 113;
    localparam int OFS_DEN    = 360000 * PI_DEN;
    localparam int OFS_HALF   = OFS_DEN / 2;
    localparam int RPM_SCALE  = 60 * 1000 * PI_DEN;
    localparam int DEN_SCALE  = 2 * PI_NUM;

    // offset divisor is 64 times an odd term below 2^20; a 50-bit dividend with a
    // 51-bit rounded-up reciprocal and a 70-bit shift gives the exact floor
    localparam int OFS_SHIFT   = 6;
    localparam int OFS_ODD     = OFS_DEN >> OFS_SHIFT;
    localparam logic [50:0] OFS_RECIP =
        51'(((128'd1 << 70) + 128'(OFS_ODD) - 128'd1) / 128'(OFS_ODD));
    localparam int OFS_DIV_LAT = 4;

    localparam logic [19:0] RADIUS_RST = 20'd33050;
    localparam logic [15:0] TRACK_RST  = 16'd160;
    localparam logic [15:0] LIMIT_RST  = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL_RADIUS = 2'd0,
        CFG_TRACK_WIDTH  = 2'd1,
        CFG_RPM_LIMIT    = 2'd2
    } cfg_idx_t;

endpackage

// ===== rtl/core/dvwr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturated to int32
module dvwr_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic                             in_neg,
    input  logic [dvwr_pkg::DIV_NUM_W-1:0]   in_mag,
    input  logic [dvwr_pkg::DIV_DEN_W-1:0]   den,
    output logic                             out_valid,
    output logic signed [31:0]               out_q
);
    import dvwr_pkg::*;

    localparam int HI_W = DIV_NUM_W - DIV_Q_W;

    logic [DIV_Q_W:0]       vld_reg;
    logic                   neg_reg [0:DIV_Q_W];
    logic                   ovf_reg [0:DIV_Q_W];
    logic [DIV_DEN_W-1:0]   rem_reg [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]     lo_reg  [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]     q_reg   [0:DIV_Q_W];
    logic                   out_valid_reg;
    logic signed [31:0]     out_q_reg;
    logic signed [31:0]     out_q_next;

    // head stage: a high part not below the divisor means the quotient needs more than 32 bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            neg_reg[0] <= in_neg;
            ovf_reg[0] <= DIV_DEN_W'(in_mag[DIV_NUM_W-1:DIV_Q_W]) >= den;
            rem_reg[0] <= DIV_DEN_W'(in_mag[DIV_NUM_W-1:DIV_Q_W]);
            lo_reg[0]  <= in_mag[DIV_Q_W-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_Q_W; k++) begin : g_step
        logic [DIV_DEN_W:0] trial;
        logic               ge;
        logic [DIV_DEN_W:0] diff;

        assign trial = {rem_reg[k-1], lo_reg[k-1][DIV_Q_W-1]};
        assign ge    = trial >= {1'b0, den};
        assign diff  = trial - {1'b0, den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                rem_reg[k] <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                lo_reg[k]  <= {lo_reg[k-1][DIV_Q_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][DIV_Q_W-2:0], ge};
            end
        end
    end

    always_comb begin
        if (neg_reg[DIV_Q_W]) begin
            if (ovf_reg[DIV_Q_W] || q_reg[DIV_Q_W][DIV_Q_W-1]) begin
                out_q_next = 32'sh8000_0000;
            end else begin
                out_q_next = -$signed(q_reg[DIV_Q_W]);
            end
        end else begin
            if (ovf_reg[DIV_Q_W] || q_reg[DIV_Q_W][DIV_Q_W-1]) begin
                out_q_next = 32'sh7fff_ffff;
            end else begin
                out_q_next = $signed(q_reg[DIV_Q_W]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[DIV_Q_W];
        end
        if (en) begin
            out_q_reg <= out_q_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_q     = out_q_reg;

endmodule

// ===== rtl/core/dvwr_offset.sv =====
// Wheel speed offset: turn rate times track scaled by pi/360000, rounded division
module dvwr_offset (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] lin,
    input  logic signed [31:0] ang,
    input  logic [15:0]        track,
    output logic               out_valid,
    output logic signed [31:0] out_lin,
    output logic signed [31:0] out_delta
);
    import dvwr_pkg::*;

    localparam logic [25:0] RECIP_LO = OFS_RECIP[25:0];
    localparam logic [24:0] RECIP_HI = OFS_RECIP[50:26];

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [48:0] p1_reg;
    logic signed [57:0] p2_reg;
    logic signed [58:0] m2;
    logic signed [31:0] lin1_reg, lin2_reg, lin3_reg;
    logic               neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [DIV_NUM_W-1:0] mag3_reg;
    logic [57:0]        mag2;
    logic [24:0]        a_lo, a_hi;
    logic [50:0]        pp_ll_reg, pp_hl_reg;
    logic [49:0]        pp_lh_reg, pp_hh_reg;
    logic [76:0]        lo_sum_reg;
    logic [100:0]       hi_sum_reg;
    logic [100:0]       total;
    logic [30:0]        q6_reg;
    logic signed [31:0] delta7_reg;
    logic signed [31:0] lin_dly_reg [0:OFS_DIV_LAT-1];

    assign m2   = p1_reg * $signed(10'(PI_NUM));
    assign mag2 = p2_reg[57] ? 58'(-p2_reg) : 58'(p2_reg);

    // drop the power-of-two part of the divisor, split the rest for the multipliers
    assign a_lo  = mag3_reg[OFS_SHIFT +: 25];
    assign a_hi  = mag3_reg[OFS_SHIFT + 25 +: 25];
    assign total = hi_sum_reg + {24'd0, lo_sum_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
        if (en) begin
            p1_reg   <= ang * $signed({1'b0, track});
            lin1_reg <= lin;
            p2_reg   <= m2[57:0];
            lin2_reg <= lin1_reg;
            neg3_reg <= p2_reg[57];
            mag3_reg <= mag2[DIV_NUM_W-1:0] + DIV_NUM_W'(OFS_HALF);
            lin3_reg <= lin2_reg;
            neg4_reg  <= neg3_reg;
            pp_ll_reg <= 51'(a_lo) * 51'(RECIP_LO);
            pp_lh_reg <= 50'(a_lo) * 50'(RECIP_HI);
            pp_hl_reg <= 51'(a_hi) * 51'(RECIP_LO);
            pp_hh_reg <= 50'(a_hi) * 50'(RECIP_HI);
            neg5_reg   <= neg4_reg;
            lo_sum_reg <= {1'b0, pp_lh_reg, 26'd0} + {26'd0, pp_ll_reg};
            hi_sum_reg <= {pp_hh_reg, 51'd0} + {25'd0, pp_hl_reg, 25'd0};
            neg6_reg   <= neg5_reg;
            q6_reg     <= total[100:70];
            // quotient stays below 2^31, so no saturation is needed
            delta7_reg <= neg6_reg ? 32'(-{1'b0, q6_reg}) : {1'b0, q6_reg};
            lin_dly_reg[0] <= lin3_reg;
            for (int i = 1; i < OFS_DIV_LAT; i++) begin
                lin_dly_reg[i] <= lin_dly_reg[i-1];
            end
        end
    end

    assign out_valid = v7_reg;
    assign out_delta = delta7_reg;
    assign out_lin   = lin_dly_reg[OFS_DIV_LAT-1];

endmodule

// ===== rtl/core/dvwr_wheel.sv =====
// One wheel: saturated speed, scaling to rpm and rounded division by the radius term
module dvwr_wheel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic                           is_left,
    input  logic signed [31:0]             lin,
    input  logic signed [31:0]             delta,
    input  logic [dvwr_pkg::DIV_DEN_W-1:0] den,
    output logic                           out_valid,
    output logic signed [31:0]             out_rpm
);
    import dvwr_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [32:0] sum;
    logic signed [31:0] spd1_reg;
    logic signed [31:0] v1_next;
    logic signed [55:0] m2;
    logic signed [54:0] p2_reg;
    logic [54:0]        mag2;
    logic               neg3_reg;
    logic [DIV_NUM_W-1:0] mag3_reg;

    assign sum = is_left ? ({lin[31], lin} - {delta[31], delta})
                         : ({lin[31], lin} + {delta[31], delta});

    always_comb begin
        if (sum[32] != sum[31]) begin
            v1_next = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            v1_next = sum[31:0];
        end
    end

    assign m2   = spd1_reg * $signed(25'(RPM_SCALE));
    assign mag2 = p2_reg[54] ? 55'(-p2_reg) : 55'(p2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            spd1_reg   <= v1_next;
            p2_reg     <= m2[54:0];
            neg3_reg   <= p2_reg[54];
            mag3_reg   <= DIV_NUM_W'(mag2) + DIV_NUM_W'(den >> 1);
        end
    end

    dvwr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_neg    (neg3_reg),
        .in_mag    (mag3_reg),
        .den       (den),
        .out_valid (out_valid),
        .out_q     (out_rpm)
    );

endmodule

// ===== rtl/core/diff_drive_velocity_to_wheel_rpm_top.sv =====
// Top level: configuration registers, offset and wheel pipelines, limit check, output register
// Turns a chassis command (linear mm/s, turn rate in millidegrees/s) into left and right wheel
// rpm. One command is taken every cycle while the result side does not stall; a command passes
// through the 7-stage offset pipeline (three arithmetic stages and a four-stage
// reciprocal-multiply divider), the 37-stage wheel pipeline (three arithmetic stages and a
// 34-stage pipelined restoring divider) and the output register. A stall on the result side
// freezes the whole pipeline. Configuration writes are registered, and the divisor is
// registered from the stored radius. Configuration writes must be made while no command is in
// flight. Zero wheel radius gives 0 rpm; a wheel over rpm_limit gives status 1 and zero outputs.
`include "diff_drive_velocity_to_wheel_rpm_top_defines.svh"
module diff_drive_velocity_to_wheel_rpm_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dvwr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dvwr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_linear_speed,
    input  logic signed [31:0]              s_turn_rate,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_left_speed_rpm,
    output logic signed [31:0]              m_right_speed_rpm,
    output logic                            m_status
);
    import dvwr_pkg::*;

    logic [19:0]          radius_reg;
    logic [15:0]          track_reg;
    logic [15:0]          limit_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic                 en;
    logic                 ofs_valid;
    logic signed [31:0]   ofs_lin, ofs_delta;
    logic                 lw_valid, rw_valid;
    logic signed [31:0]   lw_rpm, rw_rpm;
    logic signed [31:0]   l_rpm, r_rpm;
    logic [31:0]          l_mag, r_mag;
    logic                 over;
    logic                 m_valid_reg;
    logic signed [31:0]   m_left_reg, m_right_reg;
    logic                 m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            track_reg  <= TRACK_RST;
            limit_reg  <= LIMIT_RST;
            den_reg    <= DIV_DEN_W'(RADIUS_RST * DEN_SCALE);
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_WHEEL_RADIUS: radius_reg <= cfg_wdata[19:0];
                    CFG_TRACK_WIDTH:  track_reg  <= cfg_wdata[15:0];
                    CFG_RPM_LIMIT:    limit_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            den_reg <= radius_reg * 10'(DEN_SCALE);
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    dvwr_offset u_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .lin       (s_linear_speed),
        .ang       (s_turn_rate),
        .track     (track_reg),
        .out_valid (ofs_valid),
        .out_lin   (ofs_lin),
        .out_delta (ofs_delta)
    );

    dvwr_wheel u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ofs_valid),
        .is_left   (1'b1),
        .lin       (ofs_lin),
        .delta     (ofs_delta),
        .den       (den_reg),
        .out_valid (lw_valid),
        .out_rpm   (lw_rpm)
    );

    dvwr_wheel u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ofs_valid),
        .is_left   (1'b0),
        .lin       (ofs_lin),
        .delta     (ofs_delta),
        .den       (den_reg),
        .out_valid (rw_valid),
        .out_rpm   (rw_rpm)
    );

    assign l_rpm = (radius_reg == '0) ? 32'sd0 : lw_rpm;
    assign r_rpm = (radius_reg == '0) ? 32'sd0 : rw_rpm;

    // magnitude of the most negative value counts as the largest positive one
    assign l_mag = (l_rpm == 32'sh8000_0000) ? 32'h7fff_ffff
                 : (l_rpm[31] ? 32'(-l_rpm) : 32'(l_rpm));
    assign r_mag = (r_rpm == 32'sh8000_0000) ? 32'h7fff_ffff
                 : (r_rpm[31] ? 32'(-r_rpm) : 32'(r_rpm));
    assign over  = (l_mag > {16'd0, limit_reg}) || (r_mag > {16'd0, limit_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= lw_valid && rw_valid;
        end
        if (en) begin
            m_left_reg   <= over ? 32'sd0 : l_rpm;
            m_right_reg  <= over ? 32'sd0 : r_rpm;
            m_status_reg <= over;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_left_speed_rpm  = m_left_reg;
    assign m_right_speed_rpm = m_right_reg;
    assign m_status          = m_status_reg;

    `DVWR_ASSERT(a_reject_zero, aclk, aresetn,
        m_valid && m_status |-> m_left_speed_rpm == 32'sd0 && m_right_speed_rpm == 32'sd0,
        "rejected result carries non-zero rpm")
    `DVWR_ASSERT(a_zero_radius, aclk, aresetn,
        m_valid && radius_reg == '0 |-> !m_status && m_left_speed_rpm == 32'sd0
            && m_right_speed_rpm == 32'sd0,
        "zero radius gave non-zero rpm")
    `DVWR_ASSERT(a_left_limit, aclk, aresetn,
        m_valid && !m_status |-> $signed(m_left_speed_rpm) <= $signed({16'd0, limit_reg})
            && $signed(m_left_speed_rpm) >= -$signed({16'd0, limit_reg}),
        "accepted left rpm beyond limit")
    `DVWR_ASSERT(a_wheels_aligned, aclk, aresetn, lw_valid == rw_valid,
        "wheel pipelines out of step")
    `DVWR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid,
        "result valid straight after reset")

endmodule
